// File: hw/rtl/att_pkg.sv
// ----------------------------------------------------------------------------
// att_pkg: shared types and constants of the text terminal
// Grid geometry, control byte codes, channel payloads and the command
// format that passes from the byte parser to the grid engine.
// ----------------------------------------------------------------------------
package att_pkg;

    // grid geometry
    localparam int GRID_COLS     = 128;
    localparam int GRID_ROWS     = 32;
    localparam int PARAM_DEPTH   = 16;
    localparam int MAX_SGR_CODES = 16;

    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int ADDR_W    = COL_W + ROW_W;
    localparam int PCNT_W    = $clog2(PARAM_DEPTH + 1);
    localparam int SGR_CNT_W = $clog2(MAX_SGR_CODES + 1);
    localparam int NUM_W     = 16;

    // command queue
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;
    localparam logic [CFG_IDX_W-1:0] REG_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS    = 2'd1;
    localparam logic [COL_W:0] COLS_RESET = 8'd80;
    localparam logic [ROW_W:0] ROWS_RESET = 6'd25;

    localparam logic [NUM_W-1:0] NUM_LIMIT    = 16'hFFFF;
    localparam logic [7:0]       PEN_FG_RESET = 8'd7;

    // byte codes
    localparam logic [7:0] CH_BEL    = 8'h07;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_ESC    = 8'h1B;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_PMAX   = 8'h3F;
    localparam logic [7:0] CH_FMIN   = 8'h40;
    localparam logic [7:0] CH_UPPERH = 8'h48;
    localparam logic [7:0] CH_UPPERJ = 8'h4A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LOWERF = 8'h66;
    localparam logic [7:0] CH_LOWERM = 8'h6D;
    localparam logic [7:0] CH_FMAX   = 8'h7E;
    localparam logic [7:0] CH_DEL    = 8'h7F;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_PRINT,
        CMD_LF,
        CMD_CR,
        CMD_BS,
        CMD_TAB,
        CMD_POS,
        CMD_ERASE,
        CMD_READ,
        CMD_CLEAR
    } cmd_kind_t;

    typedef enum logic [1:0] {
        ERASE_TO_END,
        ERASE_TO_CURSOR,
        ERASE_ALL
    } erase_mode_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] data_byte;
        logic [7:0] read_col;
        logic [5:0] read_row;
    } item_t;

    typedef struct packed {
        logic [7:0] cell_char;
        logic [7:0] cell_fg;
        logic [7:0] cell_bg;
        logic [6:0] cursor_col;
        logic [4:0] cursor_row;
        logic [7:0] current_fg;
        logic [7:0] current_bg;
    } result_t;

    typedef struct packed {
        cmd_kind_t        kind;
        logic [7:0]       ch;
        logic [7:0]       pen_fg;
        logic [7:0]       pen_bg;
        logic [7:0]       read_col;
        logic [5:0]       read_row;
        logic [NUM_W-1:0] pos_row;
        logic [NUM_W-1:0] pos_col;
        erase_mode_t      erase_mode;
    } cmd_t;

    typedef struct packed {
        logic [COL_W:0] cols;
        logic [ROW_W:0] rows;
    } cfg_t;

endpackage

// File: hw/rtl/ansi_text_terminal_top.sv
// ----------------------------------------------------------------------------
// ansi_text_terminal_top: escape-sequence text terminal
// Byte parser and grid engine joined by a command queue, with the two
// geometry registers.
//
//   channel   direction  handshake                 payload
//   item      in         item_valid / item_ready   att_pkg::item_t
//   result    out        result_valid/result_ready att_pkg::result_t
//   config    in         wr_en                     wr_index, wr_data
//
// A simple command goes via the response state to the result register; a
// cell read first passes a read state for the registered memory read.
// The copy walker moves each row in use up one row to scroll, then the
// bottom row is blanked; an erase or clear walks up to 4096 cells, one a
// cycle. After reset a clearing pass over all 4096 cells zeroes the grid;
// item_ready stays low until it ends. A geometry write taken while idle
// clears all characters. A stalled result holds the engine; the queue
// lets the parser take up to four more transactions meanwhile.
// ----------------------------------------------------------------------------
module ansi_text_terminal_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  att_pkg::item_t                     item,
    output logic                               result_valid,
    input  logic                               result_ready,
    output att_pkg::result_t                   result,
    input  logic                               wr_en,
    input  logic [att_pkg::CFG_IDX_W-1:0]      wr_index,
    input  logic [att_pkg::CFG_DATA_W-1:0]     wr_data
);

    logic [att_pkg::COL_W:0] cols_reg, cols_next;
    logic [att_pkg::ROW_W:0] rows_reg, rows_next;
    logic                    wipe;
    att_pkg::cfg_t           cfg;

    logic                    push, pop, q_valid, q_full, init_done;
    att_pkg::cmd_t           push_cmd, q_head;

    // geometry registers with clamping
    always_comb
    begin
        cols_next = cols_reg;
        rows_next = rows_reg;
        wipe      = 1'b0;
        if (wr_en)
        begin
            case (wr_index)
                att_pkg::REG_COLUMNS:
                begin
                    wipe = 1'b1;
                    if ({1'b0, wr_data} > 9'(att_pkg::GRID_COLS))
                        cols_next = (att_pkg::COL_W + 1)'(att_pkg::GRID_COLS);
                    else if (wr_data == 8'd0)
                        cols_next = (att_pkg::COL_W + 1)'(1);
                    else
                        cols_next = (att_pkg::COL_W + 1)'(wr_data);
                end
                att_pkg::REG_ROWS:
                begin
                    wipe = 1'b1;
                    if (wr_data[5:0] > 6'(att_pkg::GRID_ROWS))
                        rows_next = (att_pkg::ROW_W + 1)'(att_pkg::GRID_ROWS);
                    else if (wr_data[5:0] == 6'd0)
                        rows_next = (att_pkg::ROW_W + 1)'(1);
                    else
                        rows_next = (att_pkg::ROW_W + 1)'(wr_data[5:0]);
                end
                default:
                    wipe = 1'b0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= att_pkg::COLS_RESET;
            rows_reg <= att_pkg::ROWS_RESET;
        end
        else
        begin
            cols_reg <= cols_next;
            rows_reg <= rows_next;
        end
    end

    assign cfg.cols = cols_reg;
    assign cfg.rows = rows_reg;

    // parser
    att_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .wipe       (wipe),
        .init_done  (init_done),
        .q_full     (q_full),
        .push       (push),
        .cmd        (push_cmd)
    );

    // command queue
    att_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .din       (push_cmd),
        .pop       (pop),
        .dout      (q_head),
        .not_empty (q_valid),
        .full      (q_full)
    );

    // grid engine
    att_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .wipe         (wipe),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (pop),
        .init_done    (init_done),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // no push into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) !(push && q_full))
        else $error("command pushed into full queue");

    // engine pops only a waiting command
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_valid)
        else $error("command popped from empty queue");

    // nothing enters while the reset clearing pass runs
    assert property (@(posedge clk) disable iff (!rst_n) !init_done |-> !push && !pop)
        else $error("transaction during clearing pass");

endmodule

// File: hw/rtl/att_front.sv
// ----------------------------------------------------------------------------
// att_front: byte parser
// Accepts transactions, runs the escape parser and the SGR pen, folds CSI
// parameters as they arrive and pushes one command per transaction.
// ----------------------------------------------------------------------------
module att_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  att_pkg::item_t   item,
    input  logic             wipe,
    input  logic             init_done,
    input  logic             q_full,
    output logic             push,
    output att_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_CSI,
        MODE_OSC
    } mode_t;

    typedef enum logic [1:0] {
        SGR_PLAIN,
        SGR_EXT,
        SGR_IDX
    } sgr_st_t;

    typedef struct packed {
        sgr_st_t    st;
        logic       bg_sel;
        logic [7:0] fg;
        logic [7:0] bg;
    } sgr_t;

    mode_t                           mode_reg, mode_next;
    logic [att_pkg::PCNT_W-1:0]      pcount_reg, pcount_next;
    logic [7:0]                      pen_fg_reg, pen_fg_next;
    logic [7:0]                      pen_bg_reg, pen_bg_next;
    logic [att_pkg::NUM_W-1:0]       num_reg, num_next;
    logic                            has_reg, has_next;
    logic [att_pkg::NUM_W-1:0]       erase_reg, erase_next;
    logic [1:0]                      slot_reg, slot_next;
    logic [att_pkg::NUM_W-1:0]       prow_reg, prow_next;
    logic [att_pkg::NUM_W-1:0]       pcol_reg, pcol_next;
    logic [att_pkg::SGR_CNT_W-1:0]   sgr_cnt_reg, sgr_cnt_next;
    sgr_t                            sgr_reg, sgr_next;

    // saturating decimal accumulate
    function automatic logic [att_pkg::NUM_W-1:0] acc_digit(
        input logic [att_pkg::NUM_W-1:0] acc,
        input logic [7:0]                b
    );
        logic [att_pkg::NUM_W+3:0] v;
        v = ({4'b0, acc} << 3) + ({4'b0, acc} << 1) + {{att_pkg::NUM_W{1'b0}}, b[3:0]};
        return (v > {4'b0, att_pkg::NUM_LIMIT}) ? att_pkg::NUM_LIMIT
                                                : v[att_pkg::NUM_W-1:0];
    endfunction

    // one SGR code with no pending extended colour
    function automatic sgr_t sgr_plain(input sgr_t s, input logic [att_pkg::NUM_W-1:0] c);
        sgr_t r;
        r    = s;
        r.st = SGR_PLAIN;
        if (c == 16'd0 || c == 16'd39)
        begin
            r.fg = att_pkg::PEN_FG_RESET;
            r.bg = 8'd0;
        end
        else if (c == 16'd49)
            r.bg = 8'd0;
        else if (c >= 16'd30 && c <= 16'd37)
            r.fg = c[7:0] - 8'd30;
        else if (c >= 16'd90 && c <= 16'd97)
            r.fg = c[7:0] - 8'd82;
        else if (c >= 16'd40 && c <= 16'd47)
            r.bg = c[7:0] - 8'd40;
        else if (c >= 16'd100 && c <= 16'd107)
            r.bg = c[7:0] - 8'd92;
        else if (c == 16'd38)
        begin
            r.st     = SGR_EXT;
            r.bg_sel = 1'b0;
        end
        else if (c == 16'd48)
        begin
            r.st     = SGR_EXT;
            r.bg_sel = 1'b1;
        end
        return r;
    endfunction

    // SGR code with 38;5;n / 48;5;n tracking
    function automatic sgr_t sgr_apply(input sgr_t s, input logic [att_pkg::NUM_W-1:0] c);
        sgr_t r;
        r = s;
        case (s.st)
            SGR_EXT:
            begin
                if (c == 16'd5)
                    r.st = SGR_IDX;
                else
                    r = sgr_plain(s, c);
            end
            SGR_IDX:
            begin
                if (s.bg_sel)
                    r.bg = c[7:0];
                else
                    r.fg = c[7:0];
                r.st = SGR_PLAIN;
            end
            default:
                r = sgr_plain(s, c);
        endcase
        return r;
    endfunction

    // handshake
    assign item_ready = init_done && !q_full;
    assign push       = item_valid && item_ready;

    // parser next state
    always_comb
    begin
        logic [7:0]                b;
        logic [att_pkg::NUM_W-1:0] val;
        logic [att_pkg::NUM_W-1:0] r_fin;
        logic [att_pkg::NUM_W-1:0] c_fin;
        sgr_t                      s_new;

        b            = item.data_byte;
        mode_next    = mode_reg;
        pcount_next  = pcount_reg;
        pen_fg_next  = pen_fg_reg;
        pen_bg_next  = pen_bg_reg;
        num_next     = num_reg;
        has_next     = has_reg;
        erase_next   = erase_reg;
        slot_next    = slot_reg;
        prow_next    = prow_reg;
        pcol_next    = pcol_reg;
        sgr_cnt_next = sgr_cnt_reg;
        sgr_next     = sgr_reg;
        val          = has_reg ? num_reg : 16'd1;
        r_fin        = prow_reg;
        c_fin        = pcol_reg;
        s_new        = sgr_reg;

        cmd            = '0;
        cmd.kind       = att_pkg::CMD_NOP;
        cmd.ch         = b;
        cmd.read_col   = item.read_col;
        cmd.read_row   = item.read_row;
        cmd.erase_mode = att_pkg::ERASE_ALL;

        if (wipe)
        begin
            mode_next   = MODE_NORMAL;
            pcount_next = '0;
            pen_fg_next = att_pkg::PEN_FG_RESET;
        end
        else if (push)
        begin
            case (item.operation)
                att_pkg::OP_PUT:
                begin
                    case (mode_reg)
                        MODE_ESC:
                        begin
                            if (b == att_pkg::CH_LBRACK)
                            begin
                                mode_next    = MODE_CSI;
                                pcount_next  = '0;
                                num_next     = '0;
                                has_next     = 1'b0;
                                erase_next   = '0;
                                slot_next    = 2'd0;
                                prow_next    = 16'd1;
                                pcol_next    = 16'd1;
                                sgr_cnt_next = '0;
                                sgr_next     = '{SGR_PLAIN, 1'b0, pen_fg_reg, pen_bg_reg};
                            end
                            else if (b == att_pkg::CH_RBRACK)
                                mode_next = MODE_OSC;
                            else
                                mode_next = MODE_NORMAL;
                        end
                        MODE_CSI:
                        begin
                            if (b >= att_pkg::CH_FMIN && b <= att_pkg::CH_FMAX)
                            begin
                                mode_next   = MODE_NORMAL;
                                pcount_next = '0;
                                if (b == att_pkg::CH_LOWERM)
                                begin
                                    if (sgr_cnt_reg < att_pkg::SGR_CNT_W'(att_pkg::MAX_SGR_CODES))
                                        s_new = sgr_apply(sgr_reg, has_reg ? num_reg : 16'd0);
                                    pen_fg_next = s_new.fg;
                                    pen_bg_next = s_new.bg;
                                end
                                else if (b == att_pkg::CH_UPPERH || b == att_pkg::CH_LOWERF)
                                begin
                                    if (slot_reg == 2'd0)
                                        r_fin = val;
                                    else if (slot_reg == 2'd1)
                                        c_fin = val;
                                    cmd.kind    = att_pkg::CMD_POS;
                                    cmd.pos_row = (r_fin == 16'd0) ? 16'd1 : r_fin;
                                    cmd.pos_col = (c_fin == 16'd0) ? 16'd1 : c_fin;
                                end
                                else if (b == att_pkg::CH_UPPERJ)
                                begin
                                    cmd.kind = att_pkg::CMD_ERASE;
                                    if (erase_reg == 16'd0)
                                        cmd.erase_mode = att_pkg::ERASE_TO_END;
                                    else if (erase_reg == 16'd1)
                                        cmd.erase_mode = att_pkg::ERASE_TO_CURSOR;
                                    else
                                        cmd.erase_mode = att_pkg::ERASE_ALL;
                                end
                            end
                            else if (b >= att_pkg::CH_SPACE && b <= att_pkg::CH_PMAX &&
                                     pcount_reg < att_pkg::PCNT_W'(att_pkg::PARAM_DEPTH))
                            begin
                                pcount_next = pcount_reg + 1'b1;
                                if (b >= att_pkg::CH_ZERO && b <= att_pkg::CH_NINE)
                                begin
                                    num_next   = acc_digit(num_reg, b);
                                    has_next   = 1'b1;
                                    erase_next = acc_digit(erase_reg, b);
                                end
                                else if (b == att_pkg::CH_SEMI)
                                begin
                                    if (slot_reg == 2'd0)
                                        prow_next = val;
                                    else if (slot_reg == 2'd1)
                                        pcol_next = val;
                                    if (slot_reg != 2'd2)
                                        slot_next = slot_reg + 1'b1;
                                    if (sgr_cnt_reg < att_pkg::SGR_CNT_W'(att_pkg::MAX_SGR_CODES))
                                    begin
                                        sgr_next     = sgr_apply(sgr_reg,
                                                                 has_reg ? num_reg : 16'd0);
                                        sgr_cnt_next = sgr_cnt_reg + 1'b1;
                                    end
                                    num_next = '0;
                                    has_next = 1'b0;
                                end
                            end
                        end
                        MODE_OSC:
                        begin
                            if (b == att_pkg::CH_BEL)
                                mode_next = MODE_NORMAL;
                        end
                        default:
                        begin
                            if (b == att_pkg::CH_ESC)
                                mode_next = MODE_ESC;
                            else if (b == att_pkg::CH_LF)
                                cmd.kind = att_pkg::CMD_LF;
                            else if (b == att_pkg::CH_CR)
                                cmd.kind = att_pkg::CMD_CR;
                            else if (b == att_pkg::CH_BS || b == att_pkg::CH_DEL)
                                cmd.kind = att_pkg::CMD_BS;
                            else if (b == att_pkg::CH_TAB)
                                cmd.kind = att_pkg::CMD_TAB;
                            else if (b >= att_pkg::CH_SPACE)
                                cmd.kind = att_pkg::CMD_PRINT;
                        end
                    endcase
                end
                att_pkg::OP_READ:
                    cmd.kind = att_pkg::CMD_READ;
                att_pkg::OP_CLEAR:
                begin
                    cmd.kind    = att_pkg::CMD_CLEAR;
                    mode_next   = MODE_NORMAL;
                    pcount_next = '0;
                    pen_fg_next = att_pkg::PEN_FG_RESET;
                end
                default:
                    cmd.kind = att_pkg::CMD_NOP;
            endcase
        end

        cmd.pen_fg = pen_fg_next;
        cmd.pen_bg = pen_bg_next;
    end

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            pcount_reg  <= '0;
            pen_fg_reg  <= att_pkg::PEN_FG_RESET;
            pen_bg_reg  <= 8'd0;
            num_reg     <= '0;
            has_reg     <= 1'b0;
            erase_reg   <= '0;
            slot_reg    <= 2'd0;
            prow_reg    <= 16'd1;
            pcol_reg    <= 16'd1;
            sgr_cnt_reg <= '0;
            sgr_reg     <= '{SGR_PLAIN, 1'b0, att_pkg::PEN_FG_RESET, 8'd0};
        end
        else
        begin
            mode_reg    <= mode_next;
            pcount_reg  <= pcount_next;
            pen_fg_reg  <= pen_fg_next;
            pen_bg_reg  <= pen_bg_next;
            num_reg     <= num_next;
            has_reg     <= has_next;
            erase_reg   <= erase_next;
            slot_reg    <= slot_next;
            prow_reg    <= prow_next;
            pcol_reg    <= pcol_next;
            sgr_cnt_reg <= sgr_cnt_next;
            sgr_reg     <= sgr_next;
        end
    end

endmodule

// File: hw/rtl/att_queue.sv
// ----------------------------------------------------------------------------
// att_queue: command queue
// Short first-in first-out buffer between the byte parser and the grid
// engine so that each side stalls on its own.
// ----------------------------------------------------------------------------
module att_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  att_pkg::cmd_t  din,
    input  logic           pop,
    output att_pkg::cmd_t  dout,
    output logic           not_empty,
    output logic           full
);

    att_pkg::cmd_t                entry_reg [att_pkg::QUEUE_DEPTH];
    logic [att_pkg::QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [att_pkg::QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [att_pkg::QCNT_W-1:0]   count_reg, count_next;

    assign dout      = entry_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == att_pkg::QCNT_W'(att_pkg::QUEUE_DEPTH));

    // pointer update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= din;
    end

endmodule

// File: hw/rtl/att_back.sv
// ----------------------------------------------------------------------------
// att_back: grid engine
// Owns the cell memories and the cursor, carries out queued commands
// (prints, scrolls, erases, reads) and holds the result register.
// ----------------------------------------------------------------------------
module att_back (
    input  logic              clk,
    input  logic              rst_n,
    input  att_pkg::cfg_t     cfg,
    input  logic              wipe,
    input  logic              q_valid,
    input  att_pkg::cmd_t     q_head,
    output logic              pop,
    output logic              init_done,
    output logic              result_valid,
    input  logic              result_ready,
    output att_pkg::result_t  result
);

    localparam int DEPTH = att_pkg::GRID_COLS * att_pkg::GRID_ROWS;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ZERO,
        ST_COPY,
        ST_READ,
        ST_RESP
    } state_t;

    state_t                            state_reg, state_next;
    logic [att_pkg::COL_W-1:0]         col_reg, col_next;
    logic [att_pkg::ROW_W-1:0]         row_reg, row_next;
    logic [att_pkg::ADDR_W-1:0]        addr_reg, addr_next;
    logic [att_pkg::ADDR_W-1:0]        end_reg, end_next;
    logic [att_pkg::ADDR_W-1:0]        prev_reg, prev_next;
    logic                              colmask_reg, colmask_next;
    logic                              zall_reg, zall_next;
    logic                              silent_reg, silent_next;
    logic                              pend_reg, pend_next;
    logic                              drain_reg, drain_next;
    logic                              in_range_reg, in_range_next;
    logic [7:0]                        pen_fg_reg, pen_fg_next;
    logic [7:0]                        pen_bg_reg, pen_bg_next;
    logic [7:0]                        cchar_reg, cchar_next;
    logic [7:0]                        cfg_reg, cfg_next;
    logic [7:0]                        cbg_reg, cbg_next;
    logic                              res_valid_reg, res_valid_next;
    att_pkg::result_t                  res_reg, res_next;

    // cell memories
    logic [7:0] char_mem [DEPTH];
    logic [7:0] fg_mem   [DEPTH];
    logic [7:0] bg_mem   [DEPTH];
    logic [7:0] rd_char_reg, rd_fg_reg, rd_bg_reg;

    logic                       we_c, we_a;
    logic [att_pkg::ADDR_W-1:0] waddr, raddr;
    logic [7:0]                 w_char, w_fg, w_bg;

    logic [att_pkg::ROW_W-1:0]  rows_m1;
    logic [att_pkg::ADDR_W-1:0] last_addr;

    assign rows_m1      = att_pkg::ROW_W'(cfg.rows - 1'b1);
    assign last_addr    = {rows_m1, {att_pkg::COL_W{1'b1}}};
    assign init_done    = (state_reg != ST_INIT);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    always_ff @(posedge clk)
    begin
        if (we_c)
            char_mem[waddr] <= w_char;
        if (we_a)
        begin
            fg_mem[waddr] <= w_fg;
            bg_mem[waddr] <= w_bg;
        end
        rd_char_reg <= char_mem[raddr];
        rd_fg_reg   <= fg_mem[raddr];
        rd_bg_reg   <= bg_mem[raddr];
    end

    // command sequencer
    always_comb
    begin
        logic                       do_lf;
        logic [att_pkg::COL_W:0]    col_p1;
        logic [att_pkg::COL_W:0]    tab;
        logic [att_pkg::ROW_W:0]    row_p1;
        logic [att_pkg::NUM_W-1:0]  pr_m1;
        logic [att_pkg::NUM_W-1:0]  pc_m1;
        logic                       col_ok;

        state_next     = state_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        addr_next      = addr_reg;
        end_next       = end_reg;
        prev_next      = prev_reg;
        colmask_next   = colmask_reg;
        zall_next      = zall_reg;
        silent_next    = silent_reg;
        pend_next      = pend_reg;
        drain_next     = drain_reg;
        in_range_next  = in_range_reg;
        pen_fg_next    = pen_fg_reg;
        pen_bg_next    = pen_bg_reg;
        cchar_next     = cchar_reg;
        cfg_next       = cfg_reg;
        cbg_next       = cbg_reg;
        res_valid_next = res_valid_reg;
        res_next       = res_reg;

        pop    = 1'b0;
        we_c   = 1'b0;
        we_a   = 1'b0;
        waddr  = addr_reg;
        raddr  = addr_reg;
        w_char = 8'd0;
        w_fg   = 8'd0;
        w_bg   = 8'd0;

        do_lf  = 1'b0;
        col_p1 = {1'b0, col_reg} + 1'b1;
        tab    = {({1'b0, col_reg[att_pkg::COL_W-1:3]} + 1'b1), 3'b000};
        row_p1 = {1'b0, row_reg} + 1'b1;
        pr_m1  = q_head.pos_row - 1'b1;
        pc_m1  = q_head.pos_col - 1'b1;
        col_ok = ({1'b0, addr_reg[att_pkg::COL_W-1:0]} < cfg.cols);

        // result register drains
        if (result_ready)
            res_valid_next = 1'b0;

        case (state_reg)
            ST_INIT:
            begin
                we_c = 1'b1;
                we_a = 1'b1;
                if (addr_reg == {att_pkg::ADDR_W{1'b1}})
                begin
                    addr_next  = '0;
                    state_next = ST_IDLE;
                end
                else
                    addr_next = addr_reg + 1'b1;
            end
            ST_IDLE:
            begin
                if (wipe)
                begin
                    col_next     = '0;
                    row_next     = '0;
                    addr_next    = '0;
                    end_next     = {att_pkg::ADDR_W{1'b1}};
                    colmask_next = 1'b0;
                    zall_next    = 1'b0;
                    silent_next  = 1'b1;
                    state_next   = ST_ZERO;
                end
                else if (q_valid)
                begin
                    pop         = 1'b1;
                    pen_fg_next = q_head.pen_fg;
                    pen_bg_next = q_head.pen_bg;
                    cchar_next  = 8'd0;
                    cfg_next    = 8'd0;
                    cbg_next    = 8'd0;
                    silent_next = 1'b0;
                    state_next  = ST_RESP;
                    case (q_head.kind)
                        att_pkg::CMD_PRINT:
                        begin
                            we_c   = 1'b1;
                            we_a   = 1'b1;
                            waddr  = {row_reg, col_reg};
                            w_char = q_head.ch;
                            w_fg   = q_head.pen_fg;
                            w_bg   = q_head.pen_bg;
                            if (col_p1 >= cfg.cols)
                                do_lf = 1'b1;
                            else
                                col_next = col_p1[att_pkg::COL_W-1:0];
                        end
                        att_pkg::CMD_LF:
                            do_lf = 1'b1;
                        att_pkg::CMD_CR:
                            col_next = '0;
                        att_pkg::CMD_BS:
                        begin
                            if (col_reg != '0)
                            begin
                                col_next = col_reg - 1'b1;
                                we_c     = 1'b1;
                                we_a     = 1'b1;
                                waddr    = {row_reg, col_reg - 1'b1};
                            end
                        end
                        att_pkg::CMD_TAB:
                        begin
                            if (tab >= cfg.cols)
                                do_lf = 1'b1;
                            else
                                col_next = tab[att_pkg::COL_W-1:0];
                        end
                        att_pkg::CMD_POS:
                        begin
                            if (pr_m1 < att_pkg::NUM_W'(cfg.rows))
                                row_next = pr_m1[att_pkg::ROW_W-1:0];
                            else
                                row_next = rows_m1;
                            if (pc_m1 < att_pkg::NUM_W'(cfg.cols))
                                col_next = pc_m1[att_pkg::COL_W-1:0];
                            else
                                col_next = att_pkg::COL_W'(cfg.cols - 1'b1);
                        end
                        att_pkg::CMD_ERASE:
                        begin
                            zall_next  = 1'b0;
                            state_next = ST_ZERO;
                            case (q_head.erase_mode)
                                att_pkg::ERASE_TO_END:
                                begin
                                    addr_next    = {row_reg, col_reg};
                                    end_next     = last_addr;
                                    colmask_next = 1'b1;
                                end
                                att_pkg::ERASE_TO_CURSOR:
                                begin
                                    addr_next    = '0;
                                    end_next     = {row_reg, col_reg};
                                    colmask_next = 1'b1;
                                end
                                default:
                                begin
                                    addr_next    = '0;
                                    end_next     = {att_pkg::ADDR_W{1'b1}};
                                    colmask_next = 1'b0;
                                end
                            endcase
                        end
                        att_pkg::CMD_CLEAR:
                        begin
                            col_next     = '0;
                            row_next     = '0;
                            addr_next    = '0;
                            end_next     = {att_pkg::ADDR_W{1'b1}};
                            colmask_next = 1'b0;
                            zall_next    = 1'b0;
                            state_next   = ST_ZERO;
                        end
                        att_pkg::CMD_READ:
                        begin
                            raddr = {q_head.read_row[att_pkg::ROW_W-1:0],
                                     q_head.read_col[att_pkg::COL_W-1:0]};
                            in_range_next =
                                (q_head.read_col < 8'(att_pkg::GRID_COLS)) &&
                                (q_head.read_row < 6'(att_pkg::GRID_ROWS));
                            state_next = ST_READ;
                        end
                        default:
                            state_next = ST_RESP;
                    endcase

                    // line feed, with scroll at the bottom row
                    if (do_lf)
                    begin
                        col_next = '0;
                        if (row_p1 >= cfg.rows)
                        begin
                            row_next = rows_m1;
                            if (rows_m1 != '0)
                            begin
                                addr_next  = att_pkg::ADDR_W'(att_pkg::GRID_COLS);
                                end_next   = last_addr;
                                pend_next  = 1'b0;
                                drain_next = 1'b0;
                                state_next = ST_COPY;
                            end
                            else
                            begin
                                addr_next    = '0;
                                end_next     = last_addr;
                                zall_next    = 1'b1;
                                colmask_next = 1'b0;
                                state_next   = ST_ZERO;
                            end
                        end
                        else
                            row_next = row_p1[att_pkg::ROW_W-1:0];
                    end
                end
            end
            ST_ZERO:
            begin
                we_c = !colmask_reg || col_ok;
                we_a = zall_reg;
                if (addr_reg == end_reg)
                    state_next = silent_reg ? ST_IDLE : ST_RESP;
                else
                    addr_next = addr_reg + 1'b1;
            end
            ST_COPY:
            begin
                // write the row above with last cycle's read
                if (pend_reg)
                begin
                    we_c   = 1'b1;
                    we_a   = 1'b1;
                    waddr  = prev_reg - att_pkg::ADDR_W'(att_pkg::GRID_COLS);
                    w_char = rd_char_reg;
                    w_fg   = rd_fg_reg;
                    w_bg   = rd_bg_reg;
                end
                if (!drain_reg)
                begin
                    prev_next = addr_reg;
                    pend_next = 1'b1;
                    if (addr_reg == end_reg)
                        drain_next = 1'b1;
                    else
                        addr_next = addr_reg + 1'b1;
                end
                else
                begin
                    pend_next    = 1'b0;
                    drain_next   = 1'b0;
                    addr_next    = {rows_m1, {att_pkg::COL_W{1'b0}}};
                    end_next     = last_addr;
                    zall_next    = 1'b1;
                    colmask_next = 1'b0;
                    state_next   = ST_ZERO;
                end
            end
            ST_READ:
            begin
                cchar_next = in_range_reg ? rd_char_reg : 8'd0;
                cfg_next   = in_range_reg ? rd_fg_reg : 8'd0;
                cbg_next   = in_range_reg ? rd_bg_reg : 8'd0;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!res_valid_reg || result_ready)
                begin
                    res_next.cell_char  = cchar_reg;
                    res_next.cell_fg    = cfg_reg;
                    res_next.cell_bg    = cbg_reg;
                    res_next.cursor_col = col_reg;
                    res_next.cursor_row = row_reg;
                    res_next.current_fg = pen_fg_reg;
                    res_next.current_bg = pen_bg_reg;
                    res_valid_next      = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // sequencer state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            col_reg       <= '0;
            row_reg       <= '0;
            addr_reg      <= '0;
            end_reg       <= '0;
            prev_reg      <= '0;
            colmask_reg   <= 1'b0;
            zall_reg      <= 1'b0;
            silent_reg    <= 1'b0;
            pend_reg      <= 1'b0;
            drain_reg     <= 1'b0;
            in_range_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            addr_reg      <= addr_next;
            end_reg       <= end_next;
            prev_reg      <= prev_next;
            colmask_reg   <= colmask_next;
            zall_reg      <= zall_next;
            silent_reg    <= silent_next;
            pend_reg      <= pend_next;
            drain_reg     <= drain_next;
            in_range_reg  <= in_range_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pen_fg_reg <= pen_fg_next;
        pen_bg_reg <= pen_bg_next;
        cchar_reg  <= cchar_next;
        cfg_reg    <= cfg_next;
        cbg_reg    <= cbg_next;
        res_reg    <= res_next;
    end

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: text terminal regression
// Drives put, read, clear and idle transactions into the terminal through the
// item channel and checks every result against a behavioural model of the
// grid, cursor, pen colours and escape parser kept in this module, or against
// the expected result of a typed row. A short directed table comes first,
// then random escape sequences, text and cell reads under several geometry
// settings, with random idling on both sides and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_top;
    import att_pkg::*;

    typedef enum int {PM_NORMAL, PM_ESC, PM_CSI, PM_OSC} parse_mode_e;

    typedef struct {
        bit      typed;
        result_t res;
    } want_t;

    typedef struct {
        item_t   it;
        bit      typed;
        result_t res;
    } row_t;

    localparam int CELLS = GRID_COLS * GRID_ROWS;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_ready;
    item_t   item = '0;
    logic    result_valid;
    logic    result_ready = 1'b0;
    result_t result;
    logic    wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  wr_index = '0;
    logic [CFG_DATA_W-1:0] wr_data = '0;

    // terminal model state
    byte unsigned    txt_mem [CELLS];
    byte unsigned    fgc_mem [CELLS];
    byte unsigned    bgc_mem [CELLS];
    byte unsigned    csi_bytes [PARAM_DEPTH];
    int              csi_len;
    int              cur_x, cur_y, ink_fg, ink_bg;
    int              vis_cols, vis_rows;
    parse_mode_e     pmode;

    result_t pending_results [$];
    want_t   typed_q [$];
    int      n_sent = 0;
    int      n_err = 0;
    int      hold_left = 0;
    bit      held = 1'b0;

    ansi_text_terminal_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .wr_en        (wr_en),
        .wr_index     (wr_index),
        .wr_data      (wr_data)
    );

    always #1 clk = ~clk;

    // model helpers
    function automatic int num_acc(int acc, byte unsigned b);
        int v;
        v = acc * 10 + (b - 8'h30);
        return (v > 65535) ? 65535 : v;
    endfunction

    function automatic bit is_dig(byte unsigned b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic void wipe_screen();
        for (int i = 0; i < CELLS; i++)
        begin
            txt_mem[i] = 0;
        end
        cur_x = 0;
        cur_y = 0;
        ink_fg = 7;
        pmode = PM_NORMAL;
        csi_len = 0;
    endfunction

    function automatic void scroll_up();
        int d;
        for (int s = GRID_COLS; s < vis_rows * GRID_COLS; s++)
        begin
            d = s - GRID_COLS;
            txt_mem[d] = txt_mem[s];
            fgc_mem[d] = fgc_mem[s];
            bgc_mem[d] = bgc_mem[s];
        end
        for (int c = 0; c < GRID_COLS; c++)
        begin
            d = (vis_rows - 1) * GRID_COLS + c;
            txt_mem[d] = 0;
            fgc_mem[d] = 0;
            bgc_mem[d] = 0;
        end
    endfunction

    function automatic void new_line();
        cur_x = 0;
        cur_y++;
        if (cur_y >= vis_rows)
        begin
            scroll_up();
            cur_y = vis_rows - 1;
        end
    endfunction

    function automatic void apply_sgr();
        int codes [MAX_SGR_CODES];
        int n, acc, c;
        bit has;
        n = 0;
        acc = 0;
        has = 0;
        for (int i = 0; i < csi_len && n < MAX_SGR_CODES; i++)
        begin
            if (is_dig(csi_bytes[i]))
            begin
                acc = num_acc(acc, csi_bytes[i]);
                has = 1;
            end
            else if (csi_bytes[i] == CH_SEMI)
            begin
                codes[n++] = has ? acc : 0;
                acc = 0;
                has = 0;
            end
        end
        if (n < MAX_SGR_CODES)
            codes[n++] = has ? acc : 0;
        for (int i = 0; i < n; i++)
        begin
            c = codes[i];
            if (c == 0 || c == 39)
            begin
                ink_fg = 7;
                ink_bg = 0;
            end
            else if (c == 49) ink_bg = 0;
            else if (c >= 30 && c <= 37) ink_fg = c - 30;
            else if (c >= 90 && c <= 97) ink_fg = c - 82;
            else if (c >= 40 && c <= 47) ink_bg = c - 40;
            else if (c >= 100 && c <= 107) ink_bg = c - 92;
            else if (c == 38 && i + 2 < n && codes[i+1] == 5)
            begin
                ink_fg = codes[i+2] & 255;
                i += 2;
            end
            else if (c == 48 && i + 2 < n && codes[i+1] == 5)
            begin
                ink_bg = codes[i+2] & 255;
                i += 2;
            end
        end
    endfunction

    function automatic void apply_position();
        int r, c, acc, slot;
        bit has;
        r = 1;
        c = 1;
        acc = 0;
        slot = 0;
        has = 0;
        for (int i = 0; i < csi_len; i++)
        begin
            if (is_dig(csi_bytes[i]))
            begin
                acc = num_acc(acc, csi_bytes[i]);
                has = 1;
            end
            else if (csi_bytes[i] == CH_SEMI)
            begin
                if (slot == 0) r = has ? acc : 1;
                else if (slot == 1) c = has ? acc : 1;
                slot++;
                acc = 0;
                has = 0;
            end
        end
        if (slot == 0) r = has ? acc : 1;
        else if (slot == 1) c = has ? acc : 1;
        if (r == 0) r = 1;
        if (c == 0) c = 1;
        cur_y = (r - 1 < vis_rows) ? r - 1 : vis_rows - 1;
        cur_x = (c - 1 < vis_cols) ? c - 1 : vis_cols - 1;
    endfunction

    function automatic void blank_span(int r, int c0, int c1);
        for (int c = c0; c < c1 && c < vis_cols; c++)
        begin
            txt_mem[r * GRID_COLS + c] = 0;
        end
    endfunction

    function automatic void apply_erase();
        int n;
        n = 0;
        for (int i = 0; i < csi_len; i++)
        begin
            if (is_dig(csi_bytes[i])) n = num_acc(n, csi_bytes[i]);
        end
        if (n == 0)
        begin
            blank_span(cur_y, cur_x, vis_cols);
            for (int r = cur_y + 1; r < vis_rows; r++) blank_span(r, 0, vis_cols);
        end
        else if (n == 1)
        begin
            for (int r = 0; r < cur_y; r++) blank_span(r, 0, vis_cols);
            blank_span(cur_y, 0, cur_x + 1);
        end
        else
        begin
            for (int i = 0; i < CELLS; i++) txt_mem[i] = 0;
        end
    endfunction

    function automatic void feed_byte(byte unsigned ch);
        int idx;
        case (pmode)
            PM_ESC:
            begin
                if (ch == CH_LBRACK)
                begin
                    csi_len = 0;
                    pmode = PM_CSI;
                end
                else if (ch == CH_RBRACK) pmode = PM_OSC;
                else pmode = PM_NORMAL;
                return;
            end
            PM_CSI:
            begin
                if (ch >= CH_FMIN && ch <= CH_FMAX)
                begin
                    pmode = PM_NORMAL;
                    if (ch == CH_LOWERM) apply_sgr();
                    else if (ch == CH_UPPERH || ch == CH_LOWERF) apply_position();
                    else if (ch == CH_UPPERJ) apply_erase();
                    csi_len = 0;
                end
                else if (ch >= CH_SPACE && ch <= CH_PMAX && csi_len < PARAM_DEPTH)
                    csi_bytes[csi_len++] = ch;
                return;
            end
            PM_OSC:
            begin
                if (ch == CH_BEL) pmode = PM_NORMAL;
                return;
            end
            default:
            begin
                if (ch == CH_ESC)
                begin
                    pmode = PM_ESC;
                    return;
                end
            end
        endcase
        if (ch == CH_LF) new_line();
        else if (ch == CH_CR) cur_x = 0;
        else if (ch == CH_BS || ch == CH_DEL)
        begin
            if (cur_x > 0)
            begin
                cur_x--;
                idx = cur_y * GRID_COLS + cur_x;
                txt_mem[idx] = 0;
                fgc_mem[idx] = 0;
                bgc_mem[idx] = 0;
            end
        end
        else if (ch == CH_TAB)
        begin
            cur_x = (cur_x / 8 + 1) * 8;
            if (cur_x >= vis_cols) new_line();
        end
        else if (ch >= CH_SPACE)
        begin
            idx = cur_y * GRID_COLS + cur_x;
            txt_mem[idx] = ch;
            fgc_mem[idx] = ink_fg[7:0];
            bgc_mem[idx] = ink_bg[7:0];
            cur_x++;
            if (cur_x >= vis_cols) new_line();
        end
    endfunction

    // works out the result of one accepted transaction and updates the model
    function automatic result_t terminal_step(item_t it);
        result_t r;
        int idx;
        r = '0;
        case (op_t'(it.operation))
            OP_PUT:   feed_byte(it.data_byte);
            OP_READ:
            begin
                if (it.read_col < GRID_COLS && it.read_row < GRID_ROWS)
                begin
                    idx = it.read_row * GRID_COLS + it.read_col;
                    r.cell_char = txt_mem[idx];
                    r.cell_fg = fgc_mem[idx];
                    r.cell_bg = bgc_mem[idx];
                end
            end
            OP_CLEAR: wipe_screen();
            default: ;
        endcase
        r.cursor_col = cur_x[6:0];
        r.cursor_row = cur_y[4:0];
        r.current_fg = ink_fg[7:0];
        r.current_bg = ink_bg[7:0];
        return r;
    endfunction

    // model tracks accepted transactions, results are checked in order
    always @(posedge clk)
    begin
        result_t p;
        want_t w;
        if (rst_n && item_valid && item_ready)
        begin
            p = terminal_step(item);
            w = typed_q.pop_front();
            pending_results.push_back(w.typed ? w.res : p);
        end
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                n_err++;
                if (n_err <= 10) $display("unexpected result %h", result);
            end
            else
            begin
                p = pending_results.pop_front();
                if (result !== p)
                begin
                    n_err++;
                    if (n_err <= 10)
                        $display("mismatch: exp ch %h fg %h bg %h cur %0d,%0d pen %h/%h",
                                 p.cell_char, p.cell_fg, p.cell_bg, p.cursor_col,
                                 p.cursor_row, p.current_fg, p.current_bg,
                                 "\n          got ch %h fg %h bg %h cur %0d,%0d pen %h/%h",
                                 result.cell_char, result.cell_fg, result.cell_bg,
                                 result.cursor_col, result.cursor_row,
                                 result.current_fg, result.current_bg);
                end
            end
        end
    end

    // receiver: random stalls plus one long hold-off to fill the queue
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            result_ready <= 1'b0;
        end
        else if (!held && n_sent >= 700)
        begin
            held <= 1'b1;
            hold_left <= 400;
            result_ready <= 1'b0;
        end
        else if (n_sent >= 300 && n_sent < 500)
            result_ready <= 1'b1;
        else
            result_ready <= ($urandom_range(0, 99) >= 19);
    end

    // sender: one transaction, with optional idle gap in front
    task automatic push_item(item_t it, bit typed = 0, result_t res = '0);
        want_t w;
        int gap;
        if (!(n_sent >= 300 && n_sent < 500) && $urandom_range(0, 99) < 19)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        else
            @(negedge clk);
        w.typed = typed;
        w.res = res;
        typed_q.push_back(w);
        item <= it;
        item_valid <= 1'b1;
        do @(posedge clk); while (!item_ready);
        n_sent++;
    endtask

    function automatic item_t mk(op_t op, byte unsigned b, int col = 0, int row = 0);
        item_t it;
        it.operation = op;
        it.data_byte = b;
        it.read_col = 8'(col);
        it.read_row = 6'(row);
        return it;
    endfunction

    task automatic put_b(byte unsigned b);
        item_t it;
        it = mk(OP_PUT, b, $urandom_range(0, 255), $urandom_range(0, 63));
        push_item(it);
    endtask

    task automatic put_str(string s);
        for (int i = 0; i < s.len(); i++) put_b(s[i]);
    endtask

    // drop valid, then wait for every accepted transaction to come back
    task automatic wait_idle();
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    // second write waits for the clearing pass of the first to finish
    task automatic write_geometry(int cols, int rows);
        @(negedge clk);
        item_valid <= 1'b0;
        wr_en <= 1'b1;
        wr_index <= REG_COLUMNS;
        wr_data <= CFG_DATA_W'(cols);
        @(negedge clk);
        wr_en <= 1'b0;
        repeat (4200) @(negedge clk);
        wr_en <= 1'b1;
        wr_index <= REG_ROWS;
        wr_data <= CFG_DATA_W'(rows);
        @(negedge clk);
        wr_en <= 1'b0;
        vis_cols = (cols & 255) > GRID_COLS ? GRID_COLS : cols & 255;
        if (vis_cols == 0) vis_cols = 1;
        vis_rows = (rows & 63) > GRID_ROWS ? GRID_ROWS : rows & 63;
        if (vis_rows == 0) vis_rows = 1;
        wipe_screen();
    endtask

    function automatic string sgr_code();
        case ($urandom_range(0, 9))
            0: return "";
            1: return $sformatf("%0d", $urandom_range(0, 1) ? 0 : 39);
            2: return "49";
            3: return $sformatf("%0d", $urandom_range(30, 37));
            4: return $sformatf("%0d", $urandom_range(90, 97));
            5: return $sformatf("%0d", $urandom_range(40, 47));
            6: return $sformatf("%0d", $urandom_range(100, 107));
            7: return $sformatf("38;5;%0d", $urandom_range(0, 999));
            8: return $sformatf("48;5;%0d", $urandom_range(0, 999));
            default: return $sformatf("%0d", $urandom_range(0, 99999));
        endcase
    endfunction

    // one random burst of related transactions
    task automatic random_group();
        string s;
        int k;
        k = $urandom_range(0, 99);
        if (k < 28)
        begin
            repeat ($urandom_range(1, 6)) put_b($urandom_range(8'h20, 8'hFF));
        end
        else if (k < 42)
        begin
            s = sgr_code();
            repeat ($urandom_range(0, 5)) s = {s, ";", sgr_code()};
            put_str({"\033[", s, "m"});
        end
        else if (k < 50)
        begin
            s = $urandom_range(0, 3) ? $sformatf("%0d", $urandom_range(0, 40)) : "";
            if ($urandom_range(0, 3))
                s = {s, ";", $urandom_range(0, 3) ? $sformatf("%0d",
                     $urandom_range(0, 140)) : ""};
            if ($urandom_range(0, 9) == 0) s = "999999;0;5";
            put_str({"\033[", s, $urandom_range(0, 1) ? "H" : "f"});
        end
        else if (k < 54)
        begin
            case ($urandom_range(0, 4))
                0: s = "";
                1: s = "0";
                2: s = "1";
                3: s = "2";
                default: s = $sformatf("%0d;%0d", $urandom_range(0, 9), $urandom_range(0, 9));
            endcase
            put_str({"\033[", s, "J"});
        end
        else if (k < 70)
        begin
            repeat ($urandom_range(1, 4))
            begin
                if ($urandom_range(0, 7) == 0)
                    push_item(mk(OP_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                                 $urandom_range(0, 63)));
                else
                    push_item(mk(OP_READ, $urandom_range(0, 255),
                                 $urandom_range(0, vis_cols - 1),
                                 $urandom_range(0, vis_rows - 1)));
            end
        end
        else if (k < 80)
        begin
            case ($urandom_range(0, 5))
                0: put_b(CH_LF);
                1: put_b(CH_CR);
                2: put_b(CH_TAB);
                3: put_b(CH_BS);
                4: put_b(CH_DEL);
                default: put_b($urandom_range(0, 31));
            endcase
        end
        else if (k < 84)
        begin
            put_str("\033]");
            repeat ($urandom_range(0, 4)) put_b($urandom_range(0, 255));
            put_b(CH_BEL);
        end
        else if (k < 87)
        begin
            put_b(CH_ESC);
            put_b($urandom_range(0, 255));
        end
        else if (k < 90)
        begin
            // parameter list of 14 to 22 bytes around the 16-byte limit, with a random final byte
            put_str("\033[");
            repeat ($urandom_range(14, 22)) put_b($urandom_range(8'h20, 8'h3F));
            if ($urandom_range(0, 3) == 0) put_b($urandom_range(0, 8'h1F));
            put_b($urandom_range(8'h40, 8'h7E));
        end
        else if (k < 99)
        begin
            // noise: any operation, any byte
            push_item(mk(op_t'($urandom_range(0, 3)), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 63)));
        end
        else
            push_item(mk(OP_CLEAR, $urandom_range(0, 255)));
    endtask

    // run limit
    initial
    begin
        #60_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // main sequence
    initial
    begin
        row_t dir_rows [$];
        row_t rw;
        int phase_cols [6] = '{128, 1, 0, 20, 200, 8};
        int phase_rows [6] = '{32, 1, 5, 4, 63, 3};
        int start;
        string s;

        for (int i = 0; i < CELLS; i++)
        begin
            txt_mem[i] = 0;
            fgc_mem[i] = 0;
            bgc_mem[i] = 0;
        end
        for (int i = 0; i < PARAM_DEPTH; i++) csi_bytes[i] = 0;
        vis_cols = COLS_RESET;
        vis_rows = ROWS_RESET;
        ink_bg = 0;
        wipe_screen();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed table: reads, extremes and each parser mode
        rw = '{mk(OP_READ, 0, 0, 0), 1, '{0, 0, 0, 0, 0, 7, 0}};
        dir_rows.push_back(rw);
        rw = '{mk(OP_READ, 8'hFF, 255, 63), 1, '{0, 0, 0, 0, 0, 7, 0}};
        dir_rows.push_back(rw);
        rw = '{mk(OP_NONE, 8'hFF, 255, 63), 1, '{0, 0, 0, 0, 0, 7, 0}};
        dir_rows.push_back(rw);
        rw = '{mk(OP_PUT, 8'h41), 1, '{0, 0, 0, 1, 0, 7, 0}};
        dir_rows.push_back(rw);
        rw = '{mk(OP_READ, 0, 0, 0), 1, '{8'h41, 7, 0, 1, 0, 7, 0}};
        dir_rows.push_back(rw);
        s = "\033[97m";
        for (int i = 0; i < s.len(); i++) dir_rows.push_back('{mk(OP_PUT, s[i]), 0, '0});
        dir_rows.push_back('{mk(OP_PUT, 8'hFF), 0, '0});
        dir_rows.push_back('{mk(OP_PUT, CH_TAB), 0, '0});
        dir_rows.push_back('{mk(OP_PUT, CH_BS), 0, '0});
        dir_rows.push_back('{mk(OP_PUT, CH_DEL), 0, '0});
        dir_rows.push_back('{mk(OP_PUT, CH_CR), 0, '0});
        dir_rows.push_back('{mk(OP_PUT, CH_LF), 0, '0});
        s = "\033]x\007\033c\001\033[2J";
        for (int i = 0; i < s.len(); i++) dir_rows.push_back('{mk(OP_PUT, s[i]), 0, '0});
        rw = '{mk(OP_CLEAR, 0), 1, '{0, 0, 0, 0, 0, 7, 0}};
        dir_rows.push_back(rw);
        foreach (dir_rows[i]) push_item(dir_rows[i].it, dir_rows[i].typed, dir_rows[i].res);

        // random phases, one geometry setting each
        for (int ph = 0; ph < 7; ph++)
        begin
            wait_idle();
            if (ph < 6) write_geometry(phase_cols[ph], phase_rows[ph]);
            else write_geometry(80, 25);
            start = n_sent;
            while (n_sent - start < 170) random_group();
        end

        @(negedge clk);
        item_valid <= 1'b0;
        wait_idle();
        if (n_err == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
